### design/tfidf_weight_table_defines.svh
// Assertion macros used by the design file tfidf_weight_table.sv.
`ifndef TFIDF_WEIGHT_TABLE_DEFINES_SVH
`define TFIDF_WEIGHT_TABLE_DEFINES_SVH

// same-cycle implication, clocked by i_clk, off during reset
`define TFW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TFW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tfw_pkg.sv
package tfw_pkg;

    // table geometry
    localparam int MAX_FILES  = 64;
    localparam int MAX_WORDS  = 256;
    localparam int COUNT_BITS = 16;
    localparam int FILE_W     = $clog2(MAX_FILES);
    localparam int WORD_W     = $clog2(MAX_WORDS);
    localparam int CELL_W     = FILE_W + WORD_W;
    localparam int CELLS      = MAX_FILES * MAX_WORDS;

    // state widths and limits
    localparam int TOTAL_W = 24;
    localparam int PRS_W   = 7;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [PRS_W-1:0]   PRS_MAX   = '1;

    // fixed-point log: mantissa in Q30, fraction in Q24
    localparam int MANT_W  = 31;
    localparam int FRAC_W  = 24;
    localparam int TOP_W   = 3;
    localparam int LOG_W   = TOP_W + FRAC_W;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // weight arithmetic
    localparam int PROD_W   = LOG_W + COUNT_BITS;
    localparam int DVD_W    = PROD_W - 8;
    localparam int WEIGHT_W = 20;
    localparam int STEP_W   = $clog2(DVD_W + 1);

    // opcodes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_IGNORE = 2'd3;

    typedef struct packed {
        logic [TOP_W-1:0]  top;
        logic [MANT_W-1:0] mant;
    } t_log_init;

    // leading-one position and normalized Q30 mantissa of a 7-bit value
    function automatic t_log_init log_init(input logic [PRS_W-1:0] x);
        t_log_init           res;
        logic [MANT_W+6:0]   wide;
        res.top = '0;
        for (int i = 1; i < PRS_W; i++) begin
            if (x[i]) res.top = TOP_W'(i);
        end
        wide     = (MANT_W+7)'({x, 30'd0}) >> res.top;
        res.mant = wide[MANT_W-1:0];
        return res;
    endfunction

endpackage

### design/tfw_ram.sv
module tfw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/tfidf_weight_table.sv
// Load and ignored opcodes pass S_READ and S_DISPATCH, then S_IDLE takes the next accept.
// A query runs S_READ, S_DISPATCH, two 24-step log2 passes, S_IDF, S_MUL and a 35-step
// divide on one shared 32x32 multiplier / subtractor; a zero total, a word in no file
// or N zero ends in S_DISPATCH, a clamped idf after the second log2 pass.
// A clear zeroes totals and presence; the result strobe is one cycle, the receiver cannot stall.
// Sync active-low reset sets files_in_use to 1, then an S_CLEAR pass zeroes totals.
`include "tfidf_weight_table_defines.svh"

module tfidf_weight_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [5:0]  i_file_index,
    input  logic [7:0]  i_word_index,
    input  logic [15:0] i_word_count,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    output logic        o_result_valid,
    output logic [19:0] o_weight_q16,
    output logic        o_empty_file
);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_DISPATCH, S_LOG_N, S_LOG_D, S_IDF, S_MUL, S_DIV, S_CLEAR
    } t_state;

    t_state r_state;

    logic [1:0]                       r_op;
    logic [tfw_pkg::FILE_W-1:0]       r_file;
    logic [tfw_pkg::WORD_W-1:0]       r_word;
    logic [tfw_pkg::COUNT_BITS-1:0]   r_cnt;
    logic [tfw_pkg::PRS_W-1:0]        r_files;
    logic [tfw_pkg::WORD_W-1:0]       r_clr;
    logic [tfw_pkg::TOTAL_W-1:0]      r_total;
    logic [tfw_pkg::COUNT_BITS-1:0]   r_cval;
    logic [tfw_pkg::MANT_W-1:0]       r_m;
    logic [tfw_pkg::TOP_W-1:0]        r_top;
    logic [tfw_pkg::FRAC_W-1:0]       r_frac;
    logic [tfw_pkg::PRS_W-1:0]        r_prs;
    logic [tfw_pkg::LOG_W-1:0]        r_ln;
    logic [tfw_pkg::LOG_W-1:0]        r_idf;
    logic [tfw_pkg::DVD_W-1:0]        r_dq;
    logic [tfw_pkg::TOTAL_W-1:0]      r_rem;
    logic [tfw_pkg::STEP_W-1:0]       r_step;
    logic                             r_valid;
    logic [tfw_pkg::WEIGHT_W-1:0]     r_weight;
    logic                             r_empty;

    // memory ports
    logic [tfw_pkg::TOTAL_W-1:0]    tot_rdata, tot_wdata;
    logic [tfw_pkg::PRS_W-1:0]      prs_rdata, prs_wdata;
    logic [tfw_pkg::COUNT_BITS-1:0] cnt_rdata;
    logic                           load_we;
    logic                           clr_we;
    logic                           mem_we;
    logic [tfw_pkg::TOTAL_W:0]      tot_sum;

    // shared unit
    logic [31:0]                  mul_a, mul_b;
    logic [63:0]                  mul_p;
    logic [31:0]                  sq;
    logic [tfw_pkg::MANT_W-1:0]   m_next;
    logic [tfw_pkg::FRAC_W-1:0]   frac_next;
    logic [tfw_pkg::LOG_W-1:0]    log_now;
    logic [tfw_pkg::TOTAL_W:0]    trial;
    logic                         ge;
    logic [tfw_pkg::DVD_W-1:0]    quo;
    tfw_pkg::t_log_init           init_n, init_d;

    assign load_we = (r_state == S_DISPATCH) && (r_op == tfw_pkg::OP_LOAD);
    assign clr_we  = (r_state == S_CLEAR);
    assign mem_we  = load_we || clr_we;

    tfw_ram #(.WIDTH(tfw_pkg::COUNT_BITS), .DEPTH(tfw_pkg::CELLS)) u_count (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr ({r_file, r_word}),
        .i_wdata (r_cnt),
        .i_raddr ({r_file, r_word}),
        .o_rdata (cnt_rdata)
    );

    tfw_ram #(.WIDTH(tfw_pkg::TOTAL_W), .DEPTH(tfw_pkg::MAX_FILES)) u_total (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (clr_we ? r_clr[tfw_pkg::FILE_W-1:0] : r_file),
        .i_wdata (tot_wdata),
        .i_raddr (r_file),
        .o_rdata (tot_rdata)
    );

    tfw_ram #(.WIDTH(tfw_pkg::PRS_W), .DEPTH(tfw_pkg::MAX_WORDS)) u_presence (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (clr_we ? r_clr : r_word),
        .i_wdata (prs_wdata),
        .i_raddr (r_word),
        .o_rdata (prs_rdata)
    );

    // load update: saturating total, saturating presence; zero during the clearing pass
    assign tot_sum   = {1'b0, tot_rdata} + (tfw_pkg::TOTAL_W + 1)'(r_cnt);
    assign tot_wdata = clr_we ? '0
                     : (tot_sum[tfw_pkg::TOTAL_W] ? tfw_pkg::TOTAL_MAX
                                                  : tot_sum[tfw_pkg::TOTAL_W-1:0]);
    assign prs_wdata = clr_we ? '0
                     : (((r_cnt != '0) && (prs_rdata != tfw_pkg::PRS_MAX)) ? prs_rdata + 1'b1
                                                                          : prs_rdata);

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_IDF: begin
                mul_a = 32'(r_idf);
                mul_b = tfw_pkg::LN2_Q32;
            end
            S_MUL: begin
                mul_a = 32'(r_idf);
                mul_b = 32'(r_cval);
            end
            default: begin
                mul_a = 32'(r_m);
                mul_b = 32'(r_m);
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // one squaring step of the log2 fraction
    assign sq        = mul_p[61:30];
    assign m_next    = sq[31] ? sq[31:1] : sq[30:0];
    assign frac_next = {r_frac[tfw_pkg::FRAC_W-2:0], sq[31]};
    assign log_now   = {r_top, frac_next};

    assign init_n = tfw_pkg::log_init(r_files);
    assign init_d = tfw_pkg::log_init(r_prs);

    // one restoring-division step
    assign trial = {r_rem, r_dq[tfw_pkg::DVD_W-1]};
    assign ge    = trial >= {1'b0, r_total};
    assign quo   = {r_dq[tfw_pkg::DVD_W-2:0], ge};

    // sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
            r_files <= tfw_pkg::PRS_W'(1);
        end else begin
            if (i_cfg_we) r_files <= i_cfg_wdata;
            case (r_state)
                S_IDLE: begin
                    r_valid <= 1'b0;
                    if (start) begin
                        r_op    <= i_opcode;
                        r_file  <= i_file_index[tfw_pkg::FILE_W-1:0];
                        r_word  <= i_word_index[tfw_pkg::WORD_W-1:0];
                        r_cnt   <= i_word_count[tfw_pkg::COUNT_BITS-1:0];
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_DISPATCH;
                S_DISPATCH: begin
                    case (r_op)
                        tfw_pkg::OP_LOAD: r_state <= S_IDLE;
                        tfw_pkg::OP_QUERY: begin
                            r_total  <= tot_rdata;
                            r_prs    <= prs_rdata;
                            r_cval   <= cnt_rdata;
                            r_weight <= '0;
                            r_empty  <= (tot_rdata == '0);
                            if (tot_rdata == '0 || prs_rdata == '0 || r_files == '0) begin
                                r_valid <= 1'b1;
                                r_state <= S_IDLE;
                            end else begin
                                r_m     <= init_n.mant;
                                r_top   <= init_n.top;
                                r_frac  <= '0;
                                r_step  <= '0;
                                r_state <= S_LOG_N;
                            end
                        end
                        tfw_pkg::OP_CLEAR: begin
                            r_clr   <= '0;
                            r_state <= S_CLEAR;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_LOG_N: begin
                    if (r_step == tfw_pkg::STEP_W'(tfw_pkg::FRAC_W - 1)) begin
                        r_ln    <= log_now;
                        r_m     <= init_d.mant;
                        r_top   <= init_d.top;
                        r_frac  <= '0;
                        r_step  <= '0;
                        r_state <= S_LOG_D;
                    end else begin
                        r_m    <= m_next;
                        r_frac <= frac_next;
                        r_step <= r_step + 1'b1;
                    end
                end
                S_LOG_D: begin
                    if (r_step == tfw_pkg::STEP_W'(tfw_pkg::FRAC_W - 1)) begin
                        if (r_ln <= log_now) begin
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_idf   <= r_ln - log_now;
                            r_state <= S_IDF;
                        end
                    end else begin
                        r_m    <= m_next;
                        r_frac <= frac_next;
                        r_step <= r_step + 1'b1;
                    end
                end
                S_IDF: begin
                    // log2 difference times ln 2
                    r_idf   <= mul_p[32 +: tfw_pkg::LOG_W];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_dq    <= mul_p[tfw_pkg::PROD_W-1:8];
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= ge ? 24'(trial - {1'b0, r_total}) : trial[tfw_pkg::TOTAL_W-1:0];
                    r_dq   <= quo;
                    r_step <= r_step + 1'b1;
                    if (r_step == tfw_pkg::STEP_W'(tfw_pkg::DVD_W - 1)) begin
                        r_weight <= (quo[tfw_pkg::DVD_W-1:tfw_pkg::WEIGHT_W] != '0)
                                    ? '1 : quo[tfw_pkg::WEIGHT_W-1:0];
                        r_valid  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_CLEAR: begin
                    // one presence entry (and one total) zeroed per cycle
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_valid;
    assign o_weight_q16   = r_weight;
    assign o_empty_file   = r_empty;

    // checks
    `TFW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transfer did not raise busy")
    `TFW_ASSERT_NOW(a_strobe_after_work, o_result_valid, $past(busy), "result without work")
    `TFW_ASSERT_NOW(a_empty_zero, o_result_valid && o_empty_file, o_weight_q16 == '0, "empty file with weight")
    `TFW_ASSERT_NOW(a_div_nonzero, r_state == S_DIV, r_total != '0, "divide by zero total")

endmodule

### test/tfidf_weight_table_tb.sv
`timescale 1ns / 1ps

module tfidf_weight_table_tb;

    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int DRAIN_CYCLES = 120;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_opcode;
    logic [5:0]  i_file_index;
    logic [7:0]  i_word_index;
    logic [15:0] i_word_count;
    logic        i_cfg_we;
    logic [6:0]  i_cfg_wdata;
    logic        o_result_valid;
    logic [19:0] o_weight_q16;
    logic        o_empty_file;

    tfidf_weight_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_file_index   (i_file_index),
        .i_word_index   (i_word_index),
        .i_word_count   (i_word_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_weight_q16   (o_weight_q16),
        .o_empty_file   (o_empty_file)
    );

    typedef struct packed {
        logic [19:0] weight;
        logic        empty;
    } t_weight_res;

    // predictor state
    logic [15:0]                 cell_count [tfw_pkg::CELLS];
    bit                          cell_loaded [tfw_pkg::CELLS];
    logic [tfw_pkg::TOTAL_W-1:0] file_total [tfw_pkg::MAX_FILES];
    logic [tfw_pkg::PRS_W-1:0]   word_docs [tfw_pkg::MAX_WORDS];
    logic [6:0]                  doc_count;

    t_weight_res expected_weights[$];
    int  mismatches;
    int  cycle_count;
    bit  idle_enabled;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // log2 in Q24 by repeated squaring of the Q30 mantissa
    function automatic logic [63:0] log2_fix(input logic [6:0] x);
        logic [63:0]  mant;
        logic [63:0]  frac;
        logic [127:0] sq;
        int           msb;
        msb = 0;
        frac = '0;
        if (x == 0) return '0;
        for (int i = 1; i < 7; i++) if (x[i]) msb = i;
        mant = (64'(x) << 30) >> msb;
        for (int i = 0; i < 24; i++) begin
            sq = 128'(mant) * 128'(mant);
            mant = 64'(sq >> 30);
            frac = frac << 1;
            if (mant >= (64'd2 << 30)) begin
                mant = mant >> 1;
                frac = frac | 64'd1;
            end
        end
        return (64'(msb) << 24) | frac;
    endfunction

    function automatic logic [63:0] idf_fix(input logic [6:0] n, input logic [6:0] d);
        logic [63:0]  ln;
        logic [63:0]  ld;
        logic [127:0] prod;
        if (d == 0 || n == 0) return '0;
        ln = log2_fix(n);
        ld = log2_fix(d);
        if (ln <= ld) return '0;
        prod = 128'(ln - ld) * 128'(tfw_pkg::LN2_Q32);
        return 64'(prod >> 32);
    endfunction

    // update the predictor for one accepted item
    task automatic predict_item(input logic [1:0] op, input logic [5:0] f,
                                input logic [7:0] w, input logic [15:0] cnt);
        int           slot;
        logic [31:0]  sum;
        logic [127:0] num;
        logic [127:0] q;
        t_weight_res  r;
        slot = int'(f) * tfw_pkg::MAX_WORDS + int'(w);
        case (op)
            tfw_pkg::OP_LOAD: begin
                cell_count[slot] = cnt;
                cell_loaded[slot] = 1'b1;
                sum = 32'(file_total[f]) + 32'(cnt);
                file_total[f] = (sum > 32'(tfw_pkg::TOTAL_MAX)) ? tfw_pkg::TOTAL_MAX
                                                                : sum[tfw_pkg::TOTAL_W-1:0];
                if (cnt != 0 && word_docs[w] < tfw_pkg::PRS_MAX)
                    word_docs[w] = word_docs[w] + 1'b1;
            end
            tfw_pkg::OP_QUERY: begin
                if (file_total[f] == 0) begin
                    r.weight = '0;
                    r.empty = 1'b1;
                end else begin
                    num = 128'(idf_fix(doc_count, word_docs[w])) * 128'(cell_count[slot]);
                    q = num / (128'(file_total[f]) << 8);
                    r.weight = (q > 128'hFFFFF) ? 20'hFFFFF : q[19:0];
                    r.empty = 1'b0;
                end
                expected_weights.insert(expected_weights.size(), r);
            end
            tfw_pkg::OP_CLEAR: begin
                foreach (file_total[i]) file_total[i] = '0;
                foreach (word_docs[i]) word_docs[i] = '0;
            end
            default: ;
        endcase
    endtask

    // compare each result strobe with the oldest expectation
    always @(posedge i_clk) begin
        t_weight_res want;
        if (i_rst_n && o_result_valid) begin
            if (expected_weights.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: weight %0d empty %0d",
                             o_weight_q16, o_empty_file);
            end else begin
                want = expected_weights.pop_front();
                if (want.weight !== o_weight_q16 || want.empty !== o_empty_file) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("weight mismatch: exp %0d/%0d got %0d/%0d",
                                 want.weight, want.empty, o_weight_q16, o_empty_file);
                end
            end
        end
    end

    task automatic idle_cycles(input int n);
        repeat (n) @(posedge i_clk);
    endtask

    // wait until the block is idle, checked away from the rising edge
    task automatic wait_idle();
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // one transfer into the block
    task automatic send_item(input logic [1:0] op, input logic [5:0] f,
                             input logic [7:0] w, input logic [15:0] cnt);
        if (idle_enabled && $urandom_range(0, 5) == 0) idle_cycles($urandom_range(1, 19));
        wait_idle();
        start <= 1'b1;
        i_opcode <= op;
        i_file_index <= f;
        i_word_index <= w;
        i_word_count <= cnt;
        // block is idle, so this edge takes the transfer
        @(posedge i_clk);
        start <= 1'b0;
        predict_item(op, f, w, cnt);
    endtask

    // wait for all results and for the block to go idle
    task automatic drain();
        while (expected_weights.size() != 0) @(posedge i_clk);
        wait_idle();
        idle_cycles(DRAIN_CYCLES);
    endtask

    task automatic write_files_in_use(input logic [6:0] n);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        doc_count = n;
    endtask

    // query a cell loaded since reset, loading it first if it is not
    task automatic query_loaded(input logic [5:0] f, input logic [7:0] w);
        if (!cell_loaded[int'(f) * tfw_pkg::MAX_WORDS + int'(w)])
            send_item(tfw_pkg::OP_LOAD, f, w, 16'($urandom_range(0, 65535)));
        send_item(tfw_pkg::OP_QUERY, f, w, 16'($urandom));
    endtask

    task automatic test_directed();
        write_files_in_use(7'd64);
        send_item(tfw_pkg::OP_QUERY, 6'd0, 8'd0, 16'd0);    // unloaded file total is zero
        send_item(tfw_pkg::OP_LOAD, 6'd0, 8'd0, 16'hFFFF);
        send_item(tfw_pkg::OP_LOAD, 6'd63, 8'd255, 16'd1);
        send_item(tfw_pkg::OP_LOAD, 6'd63, 8'd0, 16'd0);
        send_item(tfw_pkg::OP_QUERY, 6'd0, 8'd0, 16'd0);    // large weight
        send_item(tfw_pkg::OP_QUERY, 6'd63, 8'd255, 16'hFFFF);
        send_item(tfw_pkg::OP_QUERY, 6'd63, 8'd0, 16'd0);
        send_item(tfw_pkg::OP_LOAD, 6'd0, 8'd0, 16'd5);     // reloaded cell
        send_item(tfw_pkg::OP_QUERY, 6'd0, 8'd0, 16'd0);
        send_item(tfw_pkg::OP_IGNORE, 6'd5, 8'd5, 16'd5);   // ignored opcode
        send_item(tfw_pkg::OP_CLEAR, 6'd0, 8'd0, 16'd0);
        send_item(tfw_pkg::OP_QUERY, 6'd0, 8'd0, 16'd0);    // totals cleared
        send_item(tfw_pkg::OP_LOAD, 6'd1, 8'd0, 16'd3);     // new load after clear
        send_item(tfw_pkg::OP_QUERY, 6'd0, 8'd0, 16'd0);
        send_item(tfw_pkg::OP_QUERY, 6'd1, 8'd0, 16'd0);
        write_files_in_use(7'd0);                           // N zero gives a zero weight
        send_item(tfw_pkg::OP_QUERY, 6'd1, 8'd0, 16'd0);
        write_files_in_use(7'd127);
        send_item(tfw_pkg::OP_QUERY, 6'd1, 8'd0, 16'd0);
        send_item(tfw_pkg::OP_QUERY, 6'd63, 8'd255, 16'd0);
    endtask

    // total saturation and presence saturation
    task automatic test_saturation();
        send_item(tfw_pkg::OP_CLEAR, 6'd0, 8'd0, 16'd0);
        write_files_in_use(7'd1);
        // one reload past the full row pushes the total into saturation
        for (int i = 0; i < 257; i++) send_item(tfw_pkg::OP_LOAD, 6'd2, 8'(i), 16'hFFFF);
        for (int i = 0; i < 130; i++) send_item(tfw_pkg::OP_LOAD, 6'(i), 8'd7, 16'd1);
        send_item(tfw_pkg::OP_QUERY, 6'd2, 8'd9, 16'd0);
        send_item(tfw_pkg::OP_QUERY, 6'd3, 8'd7, 16'd0);
        write_files_in_use(7'd127);
        send_item(tfw_pkg::OP_QUERY, 6'd3, 8'd7, 16'd0);
    endtask

    // random mix: loads mostly into a few files, queries of loaded cells, ignored ops, clears, N writes
    task automatic test_random(input int n_items);
        int sent;
        logic [5:0] f;
        logic [7:0] w;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                write_files_in_use(7'($urandom_range(0, 127)));
                if ($urandom_range(0, 1) == 0) begin
                    send_item(tfw_pkg::OP_CLEAR, 6'($urandom), 8'($urandom), 16'($urandom));
                    sent++;
                end
            end
            f = 6'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 7));
            w = 8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 15));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    send_item(tfw_pkg::OP_LOAD, f, w,
                              16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40)));
                    sent++;
                end
                4, 5, 6, 7: begin
                    query_loaded(f, w);
                    sent += 2;
                end
                8: begin
                    send_item(tfw_pkg::OP_IGNORE, f, w, 16'($urandom));
                    sent++;
                end
                default: begin
                    send_item(tfw_pkg::OP_CLEAR, f, w, 16'($urandom));
                    sent++;
                end
            endcase
        end
    endtask

    initial begin
        mismatches = 0;
        cycle_count = 0;
        idle_enabled = 1'b0;
        doc_count = 7'd1;
        foreach (file_total[i]) file_total[i] = '0;
        foreach (word_docs[i]) word_docs[i] = '0;
        foreach (cell_loaded[i]) cell_loaded[i] = 1'b0;
        foreach (cell_count[i]) cell_count[i] = '0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_opcode = tfw_pkg::OP_LOAD;
        i_file_index = '0;
        i_word_index = '0;
        i_word_count = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset value of files_in_use is one: idf is zero
        send_item(tfw_pkg::OP_LOAD, 6'd4, 8'd4, 16'd9);
        send_item(tfw_pkg::OP_QUERY, 6'd4, 8'd4, 16'd0);
        test_directed();
        test_saturation();
        idle_enabled = 1'b1;
        test_random(700);
        drain();                                   // sender holds until all results are in
        test_random(500);
        idle_enabled = 1'b0;
        test_random(340);

        drain();
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/tfw_pkg.sv
design/tfw_ram.sv
design/tfidf_weight_table.sv
test/tfidf_weight_table_tb.sv
